>>> hw/rtl/roh_pkg.sv
`timescale 1ns / 1ps

package roh_pkg;

  localparam int ENERGY_W = 16;
  localparam int POS_W    = 16;
  localparam int LAYER_W  = 6;
  localparam int BIN_W    = 5;
  localparam int COUNT_W  = 16;
  localparam int RADIUS_W = 15;
  localparam int EDGE_W   = 20;
  localparam int SQ_W     = 2 * EDGE_W;
  localparam int R2_W     = 2 * POS_W;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_RADIUS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BIN_WIDTH  = 2'd2;

  localparam logic [ENERGY_W-1:0] THRESHOLD_RESET  = 16'd8;
  localparam logic [RADIUS_W-1:0] MIN_RADIUS_RESET = 15'd3600;
  localparam logic [RADIUS_W-1:0] BIN_WIDTH_RESET  = 15'd450;

  localparam logic KIND_HIT  = 1'b0;
  localparam logic KIND_READ = 1'b1;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam int BIN_STAGES = 4;
  localparam int OUT_DEPTH  = 8;
  localparam int OUT_PTR_W  = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W  = $clog2(OUT_DEPTH + 1);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_LOAD,
    ST_SWEEP,
    ST_RUN
  } ctrl_state_e;

  typedef struct packed {
    logic               valid;
    logic               is_read;
    logic               active;
    logic [LAYER_W-1:0] layer;
    logic [BIN_W-1:0]   bin;
  } req_t;

  typedef struct packed {
    logic [LAYER_W-1:0] layer;
    logic [BIN_W-1:0]   bin;
    logic [COUNT_W-1:0] count;
  } result_t;

endpackage

>>> hw/rtl/roh_ctrl.sv
`timescale 1ns / 1ps

module roh_ctrl import roh_pkg::*; #(
  parameter int LAYERS      = 64,
  parameter int RADIAL_BINS = 16,
  parameter int ADDR_W      = 11
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [CFG_IDX_W-1:0]               cfg_index_i,
  input  logic [CFG_DATA_W-1:0]              cfg_data_i,
  output logic [ENERGY_W-1:0]                threshold_o,
  output logic [RADIAL_BINS:0][SQ_W-1:0]     edge_sq_o,
  output logic                               clr_en_o,
  output logic [ADDR_W-1:0]                  clr_addr_o,
  output logic                               run_o
);

  localparam int DEPTH = LAYERS * (RADIAL_BINS + 2);
  localparam int K_W   = $clog2(RADIAL_BINS + 1);

  ctrl_state_e state_q, state_d;

  logic [ENERGY_W-1:0]            thr_q;
  logic [RADIUS_W-1:0]            min_q;
  logic [RADIUS_W-1:0]            bw_q;
  logic [ADDR_W-1:0]              clr_addr_q;
  logic [K_W-1:0]                 k_q;
  logic [EDGE_W-1:0]              edge_q;
  logic [RADIAL_BINS:0][SQ_W-1:0] sq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THRESHOLD_RESET;
      min_q <= MIN_RADIUS_RESET;
      bw_q  <= BIN_WIDTH_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_THRESHOLD:  thr_q <= cfg_data_i;
        CFG_MIN_RADIUS: min_q <= cfg_data_i[RADIUS_W-1:0];
        CFG_BIN_WIDTH:  bw_q  <= cfg_data_i[RADIUS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_addr_q == ADDR_W'(DEPTH - 1)) state_d = ST_LOAD;
      end
      ST_LOAD: begin
        if (!cfg_we_i) state_d = ST_SWEEP;
      end
      ST_SWEEP: begin
        if (cfg_we_i) state_d = ST_LOAD;
        else if (k_q == K_W'(RADIAL_BINS)) state_d = ST_RUN;
      end
      ST_RUN: begin
        if (cfg_we_i) state_d = ST_LOAD;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
      k_q        <= '0;
    end else begin
      if (state_q == ST_CLEAR) clr_addr_q <= clr_addr_q + ADDR_W'(1);
      if (state_q == ST_LOAD) k_q <= '0;
      else if (state_q == ST_SWEEP) k_q <= k_q + K_W'(1);
    end
  end

  // Edge k is min_radius + k * bin_width, built by repeated addition; one square per cycle.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_LOAD) begin
      edge_q <= EDGE_W'(min_q);
    end else if (state_q == ST_SWEEP) begin
      sq_q[k_q] <= edge_q * edge_q;
      edge_q    <= edge_q + EDGE_W'(bw_q);
    end
  end

  assign threshold_o = thr_q;
  assign edge_sq_o   = sq_q;
  assign clr_en_o    = (state_q == ST_CLEAR);
  assign clr_addr_o  = clr_addr_q;
  assign run_o       = (state_q == ST_RUN);

`ifndef SYNTHESIS
  a_sweep_ends_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SWEEP && !cfg_we_i && k_q == K_W'(RADIAL_BINS)) |=> run_o)
    else $error("edge sweep did not hand over to normal operation");
`endif

endmodule

>>> hw/rtl/roh_bin_pipe.sv
`timescale 1ns / 1ps

module roh_bin_pipe import roh_pkg::*; #(
  parameter int LAYERS      = 64,
  parameter int RADIAL_BINS = 16,
  parameter int ADDR_W      = 11
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           accept_i,
  input  logic                           kind_i,
  input  logic [ENERGY_W-1:0]            energy_i,
  input  logic signed [POS_W-1:0]        x_pos_i,
  input  logic signed [POS_W-1:0]        y_pos_i,
  input  logic [LAYER_W-1:0]             layer_index_i,
  input  logic [BIN_W-1:0]               read_bin_i,
  input  logic [ENERGY_W-1:0]            threshold_i,
  input  logic [RADIAL_BINS:0][SQ_W-1:0] edge_sq_i,
  output req_t                           req_o,
  output logic [ADDR_W-1:0]              addr_o,
  output logic [BIN_STAGES-1:0]          read_flags_o
);

  localparam int BINS_PER_LAYER = RADIAL_BINS + 2;

  logic                       s1_valid_q;
  logic                       s1_kind_q;
  logic [ENERGY_W-1:0]        s1_energy_q;
  logic signed [POS_W-1:0]    s1_x_q;
  logic signed [POS_W-1:0]    s1_y_q;
  logic [LAYER_W-1:0]         s1_layer_q;
  logic [BIN_W-1:0]           s1_bin_q;

  logic                       s2_valid_q;
  logic                       s2_read_q;
  logic                       s2_active_q;
  logic                       s2_active_d;
  logic [LAYER_W-1:0]         s2_layer_q;
  logic [BIN_W-1:0]           s2_bin_q;
  logic [R2_W-2:0]            s2_xx_q;
  logic [R2_W-2:0]            s2_yy_q;
  logic signed [R2_W-1:0]     xx_full;
  logic signed [R2_W-1:0]     yy_full;
  logic                       layer_ok;

  logic                       s3_valid_q;
  logic                       s3_read_q;
  logic                       s3_active_q;
  logic [LAYER_W-1:0]         s3_layer_q;
  logic [BIN_W-1:0]           s3_bin_q;
  logic [RADIAL_BINS:0]       s3_ge_q;
  logic [RADIAL_BINS:0]       ge_d;
  logic [R2_W-1:0]            r2;

  req_t                       s4_req_q;
  req_t                       s4_req_d;
  logic [ADDR_W-1:0]          s4_addr_q;
  logic [ADDR_W-1:0]          s4_addr_d;
  logic [BIN_W-1:0]           ones;
  logic [BIN_W-1:0]           hit_bin;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept_i;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      s1_kind_q   <= kind_i;
      s1_energy_q <= energy_i;
      s1_x_q      <= x_pos_i;
      s1_y_q      <= y_pos_i;
      s1_layer_q  <= layer_index_i;
      s1_bin_q    <= read_bin_i;
    end
  end

  assign xx_full  = s1_x_q * s1_x_q;
  assign yy_full  = s1_y_q * s1_y_q;
  assign layer_ok = int'(s1_layer_q) < LAYERS;

  always_comb begin
    if (s1_kind_q == KIND_READ) begin
      s2_active_d = layer_ok && (int'(s1_bin_q) <= RADIAL_BINS + 1);
    end else begin
      s2_active_d = layer_ok && (s1_energy_q > threshold_i);
    end
  end

  always_ff @(posedge clk_i) begin
    s2_read_q   <= (s1_kind_q == KIND_READ);
    s2_active_q <= s2_active_d;
    s2_layer_q  <= s1_layer_q;
    s2_bin_q    <= s1_bin_q;
    s2_xx_q     <= xx_full[R2_W-2:0];
    s2_yy_q     <= yy_full[R2_W-2:0];
  end

  assign r2 = {1'b0, s2_xx_q} + {1'b0, s2_yy_q};

  always_comb begin
    for (int k = 0; k <= RADIAL_BINS; k++) begin
      ge_d[k] = {{(SQ_W - R2_W){1'b0}}, r2} >= edge_sq_i[k];
    end
  end

  always_ff @(posedge clk_i) begin
    s3_read_q   <= s2_read_q;
    s3_active_q <= s2_active_q;
    s3_layer_q  <= s2_layer_q;
    s3_bin_q    <= s2_bin_q;
    s3_ge_q     <= ge_d;
  end

  // The edges never decrease, so the edges passed form a prefix and their count is the bin.
  assign ones = BIN_W'($countones(s3_ge_q[RADIAL_BINS:1]));

  always_comb begin
    if (!s3_ge_q[0]) begin
      hit_bin = '0;
    end else if (ones == BIN_W'(RADIAL_BINS)) begin
      hit_bin = BIN_W'(RADIAL_BINS + 1);
    end else begin
      hit_bin = ones + BIN_W'(1);
    end
  end

  always_comb begin
    s4_req_d.valid   = s3_valid_q;
    s4_req_d.is_read = s3_read_q;
    s4_req_d.active  = s3_active_q;
    s4_req_d.layer   = s3_layer_q;
    s4_req_d.bin     = s3_read_q ? s3_bin_q : hit_bin;
    s4_addr_d = ADDR_W'(int'(s3_layer_q) * BINS_PER_LAYER + int'(s4_req_d.bin));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_req_q  <= '0;
      s4_addr_q <= '0;
    end else begin
      s4_req_q  <= s4_req_d;
      s4_addr_q <= s4_addr_d;
    end
  end

  assign req_o  = s4_req_q;
  assign addr_o = s4_addr_q;
  assign read_flags_o = {s4_req_q.valid & s4_req_q.is_read,
                         s3_valid_q & s3_read_q,
                         s2_valid_q & s2_read_q,
                         s1_valid_q & (s1_kind_q == KIND_READ)};

endmodule

>>> hw/rtl/roh_count_mem.sv
`timescale 1ns / 1ps

module roh_count_mem import roh_pkg::*; #(
  parameter int LAYERS      = 64,
  parameter int RADIAL_BINS = 16,
  parameter int ADDR_W      = 11
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  req_t              req_i,
  input  logic [ADDR_W-1:0] addr_i,
  input  logic              clr_en_i,
  input  logic [ADDR_W-1:0] clr_addr_i,
  output logic              push_o,
  output result_t           result_o,
  output logic              read_flag_o
);

  localparam int DEPTH = LAYERS * (RADIAL_BINS + 2);

  logic [COUNT_W-1:0] mem [DEPTH];

  req_t               s5_req_q;
  logic [ADDR_W-1:0]  s5_addr_q;
  logic [COUNT_W-1:0] rd_data_q;
  logic               fwd_valid_q;
  logic [ADDR_W-1:0]  fwd_addr_q;
  logic [COUNT_W-1:0] fwd_data_q;
  logic [COUNT_W-1:0] old_count;
  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  logic [COUNT_W-1:0] wr_data;

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data_q <= mem[addr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_req_q    <= '0;
      fwd_valid_q <= 1'b0;
    end else begin
      s5_req_q    <= req_i;
      fwd_valid_q <= wr_en;
    end
  end

  always_ff @(posedge clk_i) begin
    s5_addr_q  <= addr_i;
    fwd_addr_q <= wr_addr;
    fwd_data_q <= wr_data;
  end

  // The word read alongside last cycle's write misses that write, so take it from the bypass.
  assign old_count = (fwd_valid_q && fwd_addr_q == s5_addr_q) ? fwd_data_q : rd_data_q;

  always_comb begin
    if (clr_en_i) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr_i;
      wr_data = '0;
    end else begin
      wr_en   = s5_req_q.valid && s5_req_q.active;
      wr_addr = s5_addr_q;
      if (s5_req_q.is_read) begin
        wr_data = '0;
      end else if (old_count == COUNT_MAX) begin
        wr_data = old_count;
      end else begin
        wr_data = old_count + COUNT_W'(1);
      end
    end
  end

  assign push_o         = s5_req_q.valid && s5_req_q.is_read;
  assign read_flag_o    = push_o;
  assign result_o.layer = s5_req_q.layer;
  assign result_o.bin   = s5_req_q.bin;
  assign result_o.count = s5_req_q.active ? old_count : '0;

`ifndef SYNTHESIS
  a_no_item_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_en_i |-> !s5_req_q.valid && !req_i.valid)
    else $error("word in the counter pipeline during the clearing pass");
`endif

endmodule

>>> hw/rtl/roh_out_fifo.sv
`timescale 1ns / 1ps

module roh_out_fifo import roh_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  result_t              data_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output result_t              data_o,
  output logic [OUT_CNT_W-1:0] count_o
);

  result_t               buf_q [OUT_DEPTH];
  logic [OUT_PTR_W-1:0]  wr_ptr_q;
  logic [OUT_PTR_W-1:0]  rd_ptr_q;
  logic [OUT_CNT_W-1:0]  cnt_q;
  logic                  pop;

  assign valid_o = (cnt_q != '0);
  assign pop     = valid_o && ready_i;
  assign data_o  = buf_q[rd_ptr_q];
  assign count_o = cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) buf_q[wr_ptr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + OUT_PTR_W'(1);
      if (pop) rd_ptr_q <= rd_ptr_q + OUT_PTR_W'(1);
      if (push_i && !pop) cnt_q <= cnt_q + OUT_CNT_W'(1);
      else if (pop && !push_i) cnt_q <= cnt_q - OUT_CNT_W'(1);
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (cnt_q != OUT_CNT_W'(OUT_DEPTH)) || pop)
    else $error("result word pushed into a full output buffer");
  a_pop_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !push_i) |=> cnt_q == $past(cnt_q) - OUT_CNT_W'(1))
    else $error("output buffer count did not drop after a pop");
`endif

endmodule

>>> hw/rtl/radial_occupancy_histogram_unit.sv
// A read word goes through stages s1 to s4, counter stage s5 and the output buffer.
// Throughput: one word per cycle; the counter memory does one read-modify-write per cycle
// through a single write port with a one-entry bypass. Input stalls outside normal operation,
// on a configuration write, or when reads in flight would overflow the eight-word buffer.
// Reset: a clearing pass over all LAYERS*(RADIAL_BINS+2) counters, then a sweep that builds
// the squared edge table; every configuration write rebuilds the table.
`timescale 1ns / 1ps

module radial_occupancy_histogram_unit import roh_pkg::*; #(
  parameter int LAYERS      = 64,
  parameter int RADIAL_BINS = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    kind_i,
  input  logic [ENERGY_W-1:0]     energy_i,
  input  logic signed [POS_W-1:0] x_pos_i,
  input  logic signed [POS_W-1:0] y_pos_i,
  input  logic [LAYER_W-1:0]      layer_index_i,
  input  logic [BIN_W-1:0]        read_bin_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [LAYER_W-1:0]      out_layer_o,
  output logic [BIN_W-1:0]        out_bin_o,
  output logic [COUNT_W-1:0]      hit_count_o
);

  localparam int ADDR_W = $clog2(LAYERS * (RADIAL_BINS + 2));

  logic [ENERGY_W-1:0]            threshold;
  logic [RADIAL_BINS:0][SQ_W-1:0] edge_sq;
  logic                           clr_en;
  logic [ADDR_W-1:0]              clr_addr;
  logic                           run;
  logic                           accept;
  req_t                           req;
  logic [ADDR_W-1:0]              req_addr;
  logic [BIN_STAGES-1:0]          pipe_reads;
  logic                           mem_read;
  logic                           push;
  result_t                        push_data;
  result_t                        head;
  logic [OUT_CNT_W-1:0]           fifo_cnt;
  logic [OUT_CNT_W:0]             reserved;

  roh_ctrl #(
    .LAYERS      (LAYERS),
    .RADIAL_BINS (RADIAL_BINS),
    .ADDR_W      (ADDR_W)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .threshold_o (threshold),
    .edge_sq_o   (edge_sq),
    .clr_en_o    (clr_en),
    .clr_addr_o  (clr_addr),
    .run_o       (run)
  );

  roh_bin_pipe #(
    .LAYERS      (LAYERS),
    .RADIAL_BINS (RADIAL_BINS),
    .ADDR_W      (ADDR_W)
  ) u_bin_pipe (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .kind_i        (kind_i),
    .energy_i      (energy_i),
    .x_pos_i       (x_pos_i),
    .y_pos_i       (y_pos_i),
    .layer_index_i (layer_index_i),
    .read_bin_i    (read_bin_i),
    .threshold_i   (threshold),
    .edge_sq_i     (edge_sq),
    .req_o         (req),
    .addr_o        (req_addr),
    .read_flags_o  (pipe_reads)
  );

  roh_count_mem #(
    .LAYERS      (LAYERS),
    .RADIAL_BINS (RADIAL_BINS),
    .ADDR_W      (ADDR_W)
  ) u_count_mem (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req),
    .addr_i      (req_addr),
    .clr_en_i    (clr_en),
    .clr_addr_i  (clr_addr),
    .push_o      (push),
    .result_o    (push_data),
    .read_flag_o (mem_read)
  );

  roh_out_fifo u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_data),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (head),
    .count_o (fifo_cnt)
  );

  // Every read in flight holds a slot in the output buffer.
  assign reserved   = {1'b0, fifo_cnt} + (OUT_CNT_W + 1)'($countones({pipe_reads, mem_read}));
  assign in_ready_o = run && !cfg_we_i && (reserved < (OUT_CNT_W + 1)'(OUT_DEPTH));
  assign accept     = in_valid_i && in_ready_o;

  assign out_layer_o = head.layer;
  assign out_bin_o   = head.bin;
  assign hit_count_o = head.count;

endmodule
